// ===== rtl/core/fpadd_pkg.sv =====
// ----------------------------------------------------------------------------
// fpadd_pkg
// Shared types and constants of the truncating single-precision adder.
// ----------------------------------------------------------------------------
package fpadd_pkg;

  localparam logic [31:0] QNAN_DEFAULT = 32'h7fc00000;
  localparam logic [30:0] INF_MAG      = 31'h7f800000;
  localparam logic [7:0]  EXP_ALL      = 8'hff;
  localparam logic [7:0]  MAX_ALIGN    = 8'd25;
  localparam int unsigned PIPE_STAGES  = 3;

  typedef struct packed {
    logic        bypass;
    logic [31:0] bypass_word;
    logic        sign;
    logic [7:0]  exp_big;
    logic        eff_sub;
    logic [25:0] mant_big;
    logic [25:0] mant_small;
  } align_t;

  typedef struct packed {
    logic        bypass;
    logic [31:0] bypass_word;
    logic        sign;
    logic [7:0]  exp_big;
    logic [26:0] mant_sum;
  } sum_t;

endpackage

// ===== rtl/core/fp32_adder_truncating.sv =====
// ----------------------------------------------------------------------------
// fp32_adder_truncating
// Truncating single-precision adder, three register stages.
//
// Channel   Direction  Ports
// request   in         start, busy, operand_a_i, operand_b_i
// result    out        done_o, sum_bits_o
//
// A request is taken in any cycle; busy stays low.
// Its result leaves the align, add and normalize registers on sum_bits_o with
// done_o high, one per request, in order.
// The latency is set by the align, add and normalize stages.
// Reset clears the valid bits only. The receiver cannot stall.
// ----------------------------------------------------------------------------
module fp32_adder_truncating (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        done_o,
  output logic [31:0] sum_bits_o
);

  fpadd_pkg::align_t align;
  fpadd_pkg::sum_t   sum;
  logic [fpadd_pkg::PIPE_STAGES-1:0] valid_q, valid_d;

  fpadd_align u_align (
    .clk_i,
    .operand_a_i,
    .operand_b_i,
    .align_o(align)
  );

  fpadd_sum u_sum (
    .clk_i,
    .align_i(align),
    .sum_o  (sum)
  );

  fpadd_norm u_norm (
    .clk_i,
    .sum_i (sum),
    .word_o(sum_bits_o)
  );

  assign busy    = 1'b0;
  assign valid_d = {valid_q[fpadd_pkg::PIPE_STAGES-2:0], start};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign done_o = valid_q[fpadd_pkg::PIPE_STAGES-1];

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##3 done_o) else $error("result lost");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(valid_q[fpadd_pkg::PIPE_STAGES-2])) else $error("spurious result");
  a_never_busy: assert property (@(posedge clk_i) !busy)
    else $error("busy raised");

endmodule

// ===== rtl/core/fpadd_align.sv =====
// ----------------------------------------------------------------------------
// fpadd_align
// Resolves special and zero-exponent operands, orders the operands by magnitude and aligns
// the smaller mantissa.
// ----------------------------------------------------------------------------
module fpadd_align (
  input  logic             clk_i,
  input  logic [31:0]      operand_a_i,
  input  logic [31:0]      operand_b_i,
  output fpadd_pkg::align_t align_o
);

  fpadd_pkg::align_t align_d, align_q;
  logic [7:0]  exp_a, exp_b, gap;
  logic        nan_a, nan_b, inf_a, inf_b;
  logic [31:0] big, lesser, special;
  logic [25:0] mant_small;

  always_comb begin
    exp_a = operand_a_i[30:23];
    exp_b = operand_b_i[30:23];
    nan_a = (exp_a == fpadd_pkg::EXP_ALL) && (operand_a_i[22:0] != '0);
    nan_b = (exp_b == fpadd_pkg::EXP_ALL) && (operand_b_i[22:0] != '0);
    inf_a = (exp_a == fpadd_pkg::EXP_ALL) && (operand_a_i[22:0] == '0);
    inf_b = (exp_b == fpadd_pkg::EXP_ALL) && (operand_b_i[22:0] == '0);
    if (nan_a) begin
      special = operand_a_i;
    end else if (nan_b) begin
      special = operand_b_i;
    end else if (inf_a && inf_b && (operand_a_i[31] != operand_b_i[31])) begin
      special = fpadd_pkg::QNAN_DEFAULT;
    end else if (inf_a) begin
      special = operand_a_i;
    end else begin
      special = operand_b_i;
    end
    if (operand_a_i[30:0] < operand_b_i[30:0]) begin
      big    = operand_b_i;
      lesser = operand_a_i;
    end else begin
      big    = operand_a_i;
      lesser = operand_b_i;
    end
    gap        = big[30:23] - lesser[30:23];
    mant_small = {1'b1, lesser[22:0], 2'b00};
    if (gap > fpadd_pkg::MAX_ALIGN) begin
      mant_small = '0;
    end else begin
      mant_small = mant_small >> gap[4:0];
    end
    align_d.bypass      = 1'b1;
    align_d.bypass_word = special;
    if (exp_a == fpadd_pkg::EXP_ALL || exp_b == fpadd_pkg::EXP_ALL) begin
      align_d.bypass_word = special;
    end else if (exp_a == '0) begin
      align_d.bypass_word = operand_b_i;
    end else if (exp_b == '0) begin
      align_d.bypass_word = operand_a_i;
    end else begin
      align_d.bypass = 1'b0;
    end
    align_d.sign       = big[31];
    align_d.exp_big    = big[30:23];
    align_d.eff_sub    = big[31] != lesser[31];
    align_d.mant_big   = {1'b1, big[22:0], 2'b00};
    align_d.mant_small = mant_small;
  end

  always_ff @(posedge clk_i) begin
    align_q <= align_d;
  end

  assign align_o = align_q;

endmodule

// ===== rtl/core/fpadd_sum.sv =====
// ----------------------------------------------------------------------------
// fpadd_sum
// Adds or subtracts the aligned mantissas.
// ----------------------------------------------------------------------------
module fpadd_sum (
  input  logic              clk_i,
  input  fpadd_pkg::align_t align_i,
  output fpadd_pkg::sum_t   sum_o
);

  fpadd_pkg::sum_t sum_d, sum_q;

  always_comb begin
    sum_d.bypass      = align_i.bypass;
    sum_d.bypass_word = align_i.bypass_word;
    sum_d.sign        = align_i.sign;
    sum_d.exp_big     = align_i.exp_big;
    if (align_i.eff_sub) begin
      sum_d.mant_sum = {1'b0, align_i.mant_big} - {1'b0, align_i.mant_small};
    end else begin
      sum_d.mant_sum = {1'b0, align_i.mant_big} + {1'b0, align_i.mant_small};
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

// ===== rtl/core/fpadd_norm.sv =====
// ----------------------------------------------------------------------------
// fpadd_norm
// Normalizes the sum by leading-one detection and packs the result word.
// ----------------------------------------------------------------------------
module fpadd_norm (
  input  logic            clk_i,
  input  fpadd_pkg::sum_t sum_i,
  output logic [31:0]     word_o
);

  logic [31:0] word_d, word_q;
  logic [4:0]  lz;
  logic [25:0] mant;
  logic [9:0]  e;

  always_comb begin
    lz = '0;
    for (int i = 0; i < 26; i++) begin
      if (sum_i.mant_sum[i]) begin
        lz = 5'(25 - i);
      end
    end
    if (sum_i.mant_sum[26]) begin
      mant = sum_i.mant_sum[26:1];
      e    = {2'b00, sum_i.exp_big} + 10'd1;
    end else begin
      mant = sum_i.mant_sum[25:0] << lz;
      e    = {2'b00, sum_i.exp_big} - {5'd0, lz};
    end
    if (sum_i.bypass) begin
      word_d = sum_i.bypass_word;
    end else if (sum_i.mant_sum == '0) begin
      word_d = '0;
    end else if (e[9] || e == '0) begin
      word_d = '0;
    end else if (e >= {2'b00, fpadd_pkg::EXP_ALL}) begin
      word_d = {sum_i.sign, fpadd_pkg::INF_MAG};
    end else begin
      word_d = {sum_i.sign, e[7:0], mant[24:2]};
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ===== sim/tb_fp32_adder_truncating.sv =====
// ----------------------------------------------------------------------------
// tb_fp32_adder_truncating
// Self-checking bench for the truncating single-precision adder. Directed
// requests are sent back to back, random requests partly with random gaps,
// and each sum is compared with a behavioral prediction held in an in-order queue.
// ----------------------------------------------------------------------------
module tb_fp32_adder_truncating;

  localparam int unsigned WatchdogLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        done_o;
  logic [31:0] sum_bits_o;

  logic [31:0] sum_queue [$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  fp32_adder_truncating dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .done_o     (done_o),
    .sum_bits_o (sum_bits_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [31:0] fp_sum(logic [31:0] x, logic [31:0] y);
    logic [31:0] big, lesser;
    logic [26:0] mb, ms;
    logic [7:0]  gap;
    int          e;
    logic        sgn;
    if (x[30:23] == fpadd_pkg::EXP_ALL || y[30:23] == fpadd_pkg::EXP_ALL) begin
      if (x[30:23] == fpadd_pkg::EXP_ALL && x[22:0] != 0) return x;
      if (y[30:23] == fpadd_pkg::EXP_ALL && y[22:0] != 0) return y;
      if (x[30:23] == fpadd_pkg::EXP_ALL && y[30:23] == fpadd_pkg::EXP_ALL) begin
        if (x[31] != y[31]) return fpadd_pkg::QNAN_DEFAULT;
        return x;
      end
      if (x[30:23] == fpadd_pkg::EXP_ALL) return x;
      return y;
    end
    if (x[30:23] == 0) return y;
    if (y[30:23] == 0) return x;
    if (x[30:0] < y[30:0]) begin
      big = y;
      lesser = x;
    end else begin
      big = x;
      lesser = y;
    end
    mb = {2'b01, big[22:0], 2'b00};
    ms = {2'b01, lesser[22:0], 2'b00};
    gap = big[30:23] - lesser[30:23];
    if (gap > fpadd_pkg::MAX_ALIGN) ms = '0;
    else ms = ms >> gap;
    e = int'(big[30:23]);
    sgn = big[31];
    if (big[31] == lesser[31]) begin
      mb = mb + ms;
      if (mb[26]) begin
        e = e + 1;
        mb = mb >> 1;
      end
    end else begin
      mb = mb - ms;
      if (mb == 0) return 32'h0;
      while (!mb[25]) begin
        mb = mb << 1;
        e = e - 1;
      end
    end
    if (e <= 0) return 32'h0;
    if (e >= 255) return {sgn, fpadd_pkg::INF_MAG};
    return {sgn, e[7:0], mb[24:2]};
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (sum_queue.size() == 0) begin
        $display("%0t: unexpected sum, expected none, actual %h", $time, sum_bits_o);
        error_count++;
      end else begin
        if (sum_bits_o !== sum_queue[0]) begin
          $display("%0t: sum_bits expected %h actual %h", $time, sum_queue[0],
                   sum_bits_o);
          error_count++;
        end
        void'(sum_queue.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int unsigned gap_length();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_request(logic [31:0] a, logic [31:0] b, bit random_gap);
    int unsigned pause;
    pause = random_gap ? gap_length() : 0;
    if (pause != 0) begin
      start <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    start <= 1'b1;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sum_queue.push_back(fp_sum(a, b));
  endtask

  task automatic drain_sums();
    start <= 1'b0;
    while (sum_queue.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_float();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 9))
      0: w[30:23] = 8'hff;
      1: w[30:23] = 8'h00;
      2: w[30:23] = 8'($urandom_range(250, 254));
      3: w[30:23] = 8'($urandom_range(1, 4));
      default: ;
    endcase
    return w;
  endfunction

  task automatic test_special_operands();
    send_request(32'h7fc00001, 32'h7f800001, 1'b0);
    send_request(32'h3f800000, 32'hff800123, 1'b0);
    send_request(32'h7f800000, 32'hff800000, 1'b0);
    send_request(32'hff800000, 32'h7f800000, 1'b0);
    send_request(32'hff800000, 32'hff800000, 1'b0);
    send_request(32'h7f800000, 32'h3f800000, 1'b0);
    send_request(32'h3f800000, 32'hff800000, 1'b0);
    send_request(32'h00000000, 32'hbf800000, 1'b0);
    send_request(32'h807fffff, 32'h00000001, 1'b0);
    send_request(32'h3f800000, 32'h00400000, 1'b0);
  endtask

  task automatic test_arithmetic_edges();
    send_request(32'h3f800000, 32'h3f800000, 1'b0);
    send_request(32'h3f800000, 32'hbf800000, 1'b0);
    send_request(32'h4b800000, 32'h3f800000, 1'b0);
    send_request(32'h4c800000, 32'h3f800000, 1'b0);
    send_request(32'h4d000000, 32'h3f800000, 1'b0);
    send_request(32'h7f7fffff, 32'h7f7fffff, 1'b0);
    send_request(32'hff7fffff, 32'hff000000, 1'b0);
    send_request(32'h00800000, 32'h80800001, 1'b0);
    send_request(32'h00ffffff, 32'h80800000, 1'b0);
    send_request(32'h3fffffff, 32'hbfffffff, 1'b0);
    send_request(32'hbf800000, 32'h3f800000, 1'b0);
    send_request(32'h3fffffff, 32'h3fffffff, 1'b0);
    send_request(32'h40000000, 32'hbfffffff, 1'b0);
    send_request(32'hffffffff, 32'h00000000, 1'b0);
    drain_sums();
  endtask

  task automatic test_random_sums();
    logic [31:0] a, b;
    for (int i = 0; i < 680; i++) begin
      a = random_float();
      b = random_float();
      if ($urandom_range(0, 3) == 0) begin
        b[30:23] = 8'(a[30:23] - $urandom_range(0, 2));
        b[31] = 1'($urandom_range(0, 1));
      end
      if (i == 340) drain_sums();
      send_request(a, b, (i % 200) > 40);
    end
    drain_sums();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_operands();
    test_arithmetic_edges();
    test_random_sums();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
